>>> design/pvth_pkg.sv
// Shared types and constants of the POLYVAL tag hasher.
package pvth_pkg;

    // Input beat modes
    localparam logic [1:0] MODE_AD     = 2'd0;
    localparam logic [1:0] MODE_MSG    = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // Register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_KEY_LO   = 2'd0;
    localparam logic [1:0] REG_KEY_HI   = 2'd1;
    localparam logic [1:0] REG_NONCE_LO = 2'd2;
    localparam logic [1:0] REG_NONCE_HI = 2'd3;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    // x^128 + x^127 + x^126 + x^121 + 1, folded into the top byte after a right shift
    localparam logic [127:0] POLY_RED = 128'hE100_0000_0000_0000_0000_0000_0000_0000;

    // Mask on the top byte of the tag (clears bit 127)
    localparam logic [7:0] TAG_TOP_MASK = 8'h7f;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
        logic        count_overflow;
    } t_out_beat;

    typedef struct packed {
        logic [127:0] hash_key;
        logic [95:0]  nonce;
    } t_cfg;

endpackage

>>> design/pvth_regs.sv
// APB register file holding the hash key and the nonce.
module pvth_regs import pvth_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [63:0] r_key_lo;
    logic [63:0] r_key_hi;
    logic [63:0] r_nonce_lo;
    logic [31:0] r_nonce_hi;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo   <= '0;
            r_key_hi   <= '0;
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KEY_LO:   r_key_lo   <= pwdata;
                REG_KEY_HI:   r_key_hi   <= pwdata;
                REG_NONCE_LO: r_nonce_lo <= pwdata;
                REG_NONCE_HI: r_nonce_hi <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_KEY_LO:   prdata = r_key_lo;
            REG_KEY_HI:   prdata = r_key_hi;
            REG_NONCE_LO: prdata = r_nonce_lo;
            REG_NONCE_HI: prdata = {32'h0, r_nonce_hi};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.hash_key = {r_key_hi, r_key_lo};
    assign o_cfg.nonce    = {r_nonce_hi, r_nonce_lo};

endmodule

>>> design/pvth_gather.sv
// Byte shift register that assembles 16-byte little-endian blocks.
module pvth_gather (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [7:0]   i_byte,
    input  logic         i_clear,
    output logic [127:0] o_block,
    output logic [3:0]   o_fill
);

    logic [127:0] r_block;
    logic [3:0]   r_fill;

    // New bytes enter at the top; after 16 pushes byte 0 sits in bits 7:0.
    // A block is only folded after 16 pushes, so the data needs no clearing.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_block <= {i_byte, r_block[127:8]};
        end
    end

    // Fill count wraps to zero on the sixteenth byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_clear) begin
            r_fill <= '0;
        end else if (i_push) begin
            r_fill <= r_fill + 4'd1;
        end
    end

    assign o_block = r_block;
    assign o_fill  = r_fill;

endmodule

>>> design/pvth_fold.sv
// Bit-serial POLYVAL fold: acc = (acc ^ block) * H * x^-128, one bit per cycle.
module pvth_fold import pvth_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_clear,
    input  logic [127:0] i_block,
    input  logic [127:0] i_key,
    output logic [127:0] o_acc,
    output logic         o_done
);

    logic [127:0] r_acc;
    logic [127:0] r_x;
    logic [127:0] r_prod;
    logic [6:0]   r_cnt;
    logic         r_busy;
    logic [127:0] mix;
    logic [127:0] n_prod;

    // One multiplier bit: add H if set, then divide by x with reduction
    always_comb begin
        mix    = r_prod ^ (r_x[0] ? i_key : '0);
        n_prod = {1'b0, mix[127:1]} ^ (mix[0] ? POLY_RED : '0);
    end

    assign o_done = r_busy && (r_cnt == 7'd127);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Operand shift register and partial product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= r_acc ^ i_block;
            r_prod <= '0;
        end else if (r_busy) begin
            r_x    <= {1'b0, r_x[127:1]};
            r_prod <= n_prod;
        end
    end

    // Accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_clear) begin
            r_acc <= '0;
        end else if (o_done) begin
            r_acc <= n_prod;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> design/polyval_tag_hasher.sv
// Byte beats: a beat that completes a block holds the input side while the block is folded.
// First message beat after a partial AD block: taken once that block is zero-padded and folded.
// Finish: pad and fold any partial block, then fold the length block bit-serially
// and wait for a free output register, which then takes the tag beat.
// One beat in flight at a time; the output register frees the input side.
// Synchronous active-low reset zeroes key, nonce, counts and accumulator; control goes idle.
module polyval_tag_hasher import pvth_pkg::*; #(
    parameter int COUNT_BITS = 36
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_beat,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_BLK   = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_LEN   = 7'b0010000,
        S_LWAIT = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_ad_cnt, n_ad_cnt;
    logic [COUNT_BITS-1:0] r_msg_cnt, n_msg_cnt;
    logic                  r_in_msg, n_in_msg;
    logic                  r_ovf, n_ovf;
    logic                  r_fin, n_fin;
    logic                  r_enter, n_enter;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out_beat;

    t_cfg         cfg;
    logic         g_push;
    logic [7:0]   g_byte;
    logic         g_clear;
    logic [127:0] g_block;
    logic [3:0]   g_fill;
    logic         f_start;
    logic         f_clear;
    logic [127:0] f_block;
    logic [127:0] f_acc;
    logic         f_done;
    logic         in_fire;
    logic         needs_flush;
    logic         load_out;
    logic [63:0]  len_lo;
    logic [63:0]  len_hi;
    logic [63:0]  tag_lo;
    logic [63:0]  tag_hi;

    pvth_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pvth_gather u_gather (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (g_push),
        .i_byte  (g_byte),
        .i_clear (g_clear),
        .o_block (g_block),
        .o_fill  (g_fill)
    );

    pvth_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (f_start),
        .i_clear (f_clear),
        .i_block (f_block),
        .i_key   (cfg.hash_key),
        .o_acc   (f_acc),
        .o_done  (f_done)
    );

    // First message beat behind a partial AD block waits while the block is padded and folded
    assign needs_flush = i_in_valid && (i_in_beat.mode == MODE_MSG) && !r_in_msg
                         && (g_fill != 4'd0);
    assign o_in_ready  = (r_state == S_IDLE) && !needs_flush;
    assign in_fire     = i_in_valid && o_in_ready;

    // Length block: bit counts
    assign len_lo = 64'({r_ad_cnt, 3'b000});
    assign len_hi = 64'({r_msg_cnt, 3'b000});

    // Tag: accumulator xor nonce, bit 127 cleared
    assign tag_lo = f_acc[63:0] ^ cfg.nonce[63:0];
    assign tag_hi = f_acc[127:64] ^ {32'h0, cfg.nonce[95:64]};

    // Control
    always_comb begin
        n_state     = r_state;
        n_ad_cnt    = r_ad_cnt;
        n_msg_cnt   = r_msg_cnt;
        n_in_msg    = r_in_msg;
        n_ovf       = r_ovf;
        n_fin       = r_fin;
        n_enter     = r_enter;
        n_out_valid = r_out_valid && !i_out_ready;
        load_out    = 1'b0;
        g_push      = 1'b0;
        g_byte      = i_in_beat.data_byte;
        g_clear     = 1'b0;
        f_start     = 1'b0;
        f_clear     = 1'b0;
        f_block     = g_block;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_beat.mode)
                        MODE_AD: begin
                            if (!r_in_msg) begin
                                g_push = 1'b1;
                                if (r_ad_cnt == '1) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_ad_cnt = r_ad_cnt + COUNT_BITS'(1);
                                end
                                if (g_fill == 4'd15) begin
                                    n_state = S_BLK;
                                end
                            end
                        end
                        MODE_MSG: begin
                            n_in_msg = 1'b1;
                            g_push   = 1'b1;
                            if (r_msg_cnt == '1) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_msg_cnt = r_msg_cnt + COUNT_BITS'(1);
                            end
                            if (g_fill == 4'd15) begin
                                n_state = S_BLK;
                            end
                        end
                        MODE_FINISH: begin
                            n_fin   = 1'b1;
                            n_state = (g_fill != 4'd0) ? S_PAD : S_LEN;
                        end
                        MODE_CLEAR: begin
                            n_ad_cnt  = '0;
                            n_msg_cnt = '0;
                            n_in_msg  = 1'b0;
                            n_ovf     = 1'b0;
                            n_fin     = 1'b0;
                            n_enter   = 1'b0;
                            g_clear   = 1'b1;
                            f_clear   = 1'b1;
                        end
                        default: ;
                    endcase
                end else if (needs_flush) begin
                    n_enter = 1'b1;
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                // zero padding, one byte per cycle
                g_push = 1'b1;
                g_byte = 8'h00;
                if (g_fill == 4'd15) begin
                    n_state = S_BLK;
                end
            end
            S_BLK: begin
                f_start = 1'b1;
                g_clear = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (f_done) begin
                    n_state = r_fin ? S_LEN : S_IDLE;
                    if (r_enter) begin
                        n_in_msg = 1'b1;
                        n_enter  = 1'b0;
                    end
                end
            end
            S_LEN: begin
                f_start = 1'b1;
                f_block = {len_hi, len_lo};
                n_state = S_LWAIT;
            end
            S_LWAIT: begin
                if (f_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_ad_cnt    = '0;
                    n_msg_cnt   = '0;
                    n_in_msg    = 1'b0;
                    n_ovf       = 1'b0;
                    n_fin       = 1'b0;
                    n_enter     = 1'b0;
                    g_clear     = 1'b1;
                    f_clear     = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ad_cnt    <= '0;
            r_msg_cnt   <= '0;
            r_in_msg    <= 1'b0;
            r_ovf       <= 1'b0;
            r_fin       <= 1'b0;
            r_enter     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ad_cnt    <= n_ad_cnt;
            r_msg_cnt   <= n_msg_cnt;
            r_in_msg    <= n_in_msg;
            r_ovf       <= n_ovf;
            r_fin       <= n_fin;
            r_enter     <= n_enter;
            r_out_valid <= n_out_valid;
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_beat.tag_low        <= tag_lo;
            r_out_beat.tag_high       <= {tag_hi[63:56] & TAG_TOP_MASK, tag_hi[55:0]};
            r_out_beat.count_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule
